>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mfm_pkg.sv
// ----------------------------------------------------------------------------
// mfm_pkg
// shared types, constants and the crc helper of the mfm track formatter
// ----------------------------------------------------------------------------
`default_nettype none

package mfm_pkg;

    localparam int TABLE_BYTES = 128;
    localparam int MAX_SECTORS = 64;

    localparam int CNT_W    = 11;
    localparam int SEC_W    = 7;
    localparam int POS_W    = 13;
    localparam int ACC_W    = 14;
    localparam int LAYOUT_W = 18;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] GAP_BYTE   = 8'h4e;
    localparam logic [7:0] SYNC_BYTE  = 8'h00;
    localparam logic [7:0] IMARK_BYTE = 8'hc2;
    localparam logic [7:0] IAM_BYTE   = 8'hfc;
    localparam logic [7:0] A1_BYTE    = 8'ha1;
    localparam logic [7:0] IDAM_BYTE  = 8'hfe;
    localparam logic [7:0] DAM_BYTE   = 8'hfb;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [CNT_W-1:0] SYNC_LEN = 11'd12;
    localparam logic [CNT_W-1:0] MARK_LEN = 11'd3;
    localparam logic [CNT_W-1:0] ONE_LEN  = 11'd1;
    localparam logic [CNT_W-1:0] CHRN_LEN = 11'd4;
    localparam logic [CNT_W-1:0] CRC_LEN  = 11'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_ONE     = 3'd0,
        CFG_GAP_TWO     = 3'd1,
        CFG_GAP_THREE   = 3'd2,
        CFG_GAP_FOUR_A  = 3'd3,
        CFG_SECTORS     = 3'd4,
        CFG_SIZE_CODE   = 3'd5
    } cfg_index_t;

    typedef enum logic [19:0] {
        PH_IDLE   = 20'h00001,
        PH_TABLE  = 20'h00002,
        PH_GAP4A  = 20'h00004,
        PH_ISYNC  = 20'h00008,
        PH_IMARK  = 20'h00010,
        PH_IFC    = 20'h00020,
        PH_GAP1   = 20'h00040,
        PH_SSYNC  = 20'h00080,
        PH_IDA1   = 20'h00100,
        PH_IDFE   = 20'h00200,
        PH_IDCHRN = 20'h00400,
        PH_IDCRC  = 20'h00800,
        PH_GAP2   = 20'h01000,
        PH_DSYNC  = 20'h02000,
        PH_DA1    = 20'h04000,
        PH_DFB    = 20'h08000,
        PH_DATA   = 20'h10000,
        PH_DCRC   = 20'h20000,
        PH_GAP3   = 20'h40000,
        PH_GAP4B  = 20'h80000
    } phase_t;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       data_taken;
        logic       last_of_track;
        logic       layout_error;
    } result_t;

    // crc-16-ccitt, msb first, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/mfm_out_buf.sv
// ----------------------------------------------------------------------------
// mfm_out_buf
// result register with a skid stage, decouples the result side from intake
// ----------------------------------------------------------------------------
`default_nettype none

module mfm_out_buf
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mfm_pkg::result_t push_item,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output mfm_pkg::result_t      out_item,
    output logic                  full
);
    import mfm_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_item_reg;
    result_t skid_item_reg;
    logic    out_fire;

    assign out_fire  = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_item_reg <= skid_item_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_item_reg <= push_item;
            end
            else
            begin
                skid_item_reg <= push_item;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/mfm_core.sv
// ----------------------------------------------------------------------------
// mfm_core
// configuration registers, track sequencer, offset table and crc datapath
// ----------------------------------------------------------------------------
`default_nettype none

module mfm_core
#(
    parameter int TRACK_BYTES = 6250
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            in_fire,
    input  wire logic                            req_type,
    input  wire logic [7:0]                      cylinder_number,
    input  wire logic                            head_number,
    input  wire logic [7:0]                      data_byte,
    output logic                                 res_valid,
    output mfm_pkg::result_t                     res
);
    import mfm_pkg::*;

    localparam logic [ACC_W-1:0]    TABLE_LIMIT = ACC_W'(TABLE_BYTES + TRACK_BYTES);
    localparam logic [ACC_W:0]      POS_LIMIT   = (ACC_W + 1)'(TRACK_BYTES);
    localparam logic [LAYOUT_W-1:0] LAYOUT_MAX  = LAYOUT_W'(TRACK_BYTES);
    localparam logic [ACC_W-1:0]    ACC_SAT     = {ACC_W{1'b1}};

    // configuration
    logic [7:0]       gap_one_reg;
    logic [7:0]       gap_two_reg;
    logic [7:0]       gap_three_reg;
    logic [7:0]       gap_four_a_reg;
    logic [SEC_W-1:0] sectors_reg;
    logic [1:0]       size_code_reg;

    // track state
    phase_t           phase_reg,   phase_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [SEC_W-1:0] sector_reg,  sector_next;
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [15:0]      crc_reg,     crc_next;
    logic [7:0]       cyl_reg,     cyl_next;
    logic             head_reg,    head_next;
    logic [ACC_W-1:0] accum_reg,   accum_next;
    logic             overrun_reg, overrun_next;

    logic [SEC_W-1:0]    eff_sectors;
    logic [CNT_W-1:0]    sector_bytes;
    logic [CNT_W-1:0]    raw_len;
    logic [LAYOUT_W-1:0] layout;

    // phase resolution, two skip steps
    logic             step1, step2;
    phase_t           ph1, ph2;
    logic [CNT_W-1:0] cnt1, cnt2;
    logic [SEC_W-1:0] si1, si2, si_inc0, si_inc1;

    logic [5:0]       entry;
    logic             entry_ok;
    logic [ACC_W:0]   accum_sum;
    logic [7:0]       tbyte;
    logic [15:0]      crc_base;
    logic             crc_phase;
    result_t          res_c;

    function automatic logic phase_done(input phase_t ph, input logic [CNT_W-1:0] cnt,
                                        input logic [7:0] g1, input logic [7:0] g2,
                                        input logic [7:0] g3, input logic [7:0] g4a,
                                        input logic [CNT_W-1:0] sb);
        logic done;
        unique case (ph)
            PH_GAP4A:                     done = cnt >= CNT_W'(g4a);
            PH_ISYNC, PH_SSYNC, PH_DSYNC: done = cnt >= SYNC_LEN;
            PH_IMARK, PH_IDA1, PH_DA1:    done = cnt >= MARK_LEN;
            PH_IFC, PH_IDFE, PH_DFB:      done = cnt >= ONE_LEN;
            PH_GAP1:                      done = cnt >= CNT_W'(g1);
            PH_IDCHRN:                    done = cnt >= CHRN_LEN;
            PH_IDCRC, PH_DCRC:            done = cnt >= CRC_LEN;
            PH_GAP2:                      done = cnt >= CNT_W'(g2);
            PH_DATA:                      done = cnt >= sb;
            PH_GAP3:                      done = cnt >= CNT_W'(g3);
            default:                      done = 1'b0;
        endcase
        return done;
    endfunction

    function automatic phase_t adv_phase(input phase_t ph, input logic [SEC_W-1:0] si_inc,
                                         input logic [SEC_W-1:0] eff);
        phase_t nxt;
        unique case (ph)
            PH_GAP4A:  nxt = PH_ISYNC;
            PH_ISYNC:  nxt = PH_IMARK;
            PH_IMARK:  nxt = PH_IFC;
            PH_IFC:    nxt = PH_GAP1;
            PH_GAP1:   nxt = (eff != '0) ? PH_SSYNC : PH_GAP4B;
            PH_SSYNC:  nxt = PH_IDA1;
            PH_IDA1:   nxt = PH_IDFE;
            PH_IDFE:   nxt = PH_IDCHRN;
            PH_IDCHRN: nxt = PH_IDCRC;
            PH_IDCRC:  nxt = PH_GAP2;
            PH_GAP2:   nxt = PH_DSYNC;
            PH_DSYNC:  nxt = PH_DA1;
            PH_DA1:    nxt = PH_DFB;
            PH_DFB:    nxt = PH_DATA;
            PH_DATA:   nxt = PH_DCRC;
            PH_DCRC:   nxt = PH_GAP3;
            PH_GAP3:   nxt = (si_inc < eff) ? PH_SSYNC : PH_GAP4B;
            default:   nxt = ph;
        endcase
        return nxt;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_one_reg    <= 8'd50;
            gap_two_reg    <= 8'd22;
            gap_three_reg  <= 8'd34;
            gap_four_a_reg <= 8'd80;
            sectors_reg    <= 7'd17;
            size_code_reg  <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_ONE:    gap_one_reg    <= cfg_data;
                CFG_GAP_TWO:    gap_two_reg    <= cfg_data;
                CFG_GAP_THREE:  gap_three_reg  <= cfg_data;
                CFG_GAP_FOUR_A: gap_four_a_reg <= cfg_data;
                CFG_SECTORS:    sectors_reg    <= cfg_data[SEC_W-1:0];
                CFG_SIZE_CODE:  size_code_reg  <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    assign eff_sectors  = (sectors_reg > SEC_W'(MAX_SECTORS)) ? SEC_W'(MAX_SECTORS)
                                                              : sectors_reg;
    assign sector_bytes = CNT_W'(TABLE_BYTES) << size_code_reg;
    assign raw_len      = CNT_W'(40) + CNT_W'(gap_two_reg) + sector_bytes
                        + CNT_W'(gap_three_reg);
    assign layout       = LAYOUT_W'(gap_four_a_reg) + LAYOUT_W'(gap_one_reg)
                        + LAYOUT_W'(16) + LAYOUT_W'(eff_sectors) * LAYOUT_W'(raw_len);

    // skip finished and empty fields
    always_comb
    begin
        si_inc0 = sector_reg + 1'b1;
        step1   = phase_done(phase_reg, count_reg, gap_one_reg, gap_two_reg,
                             gap_three_reg, gap_four_a_reg, sector_bytes);
        ph1     = step1 ? adv_phase(phase_reg, si_inc0, eff_sectors) : phase_reg;
        si1     = (step1 && phase_reg == PH_GAP3) ? si_inc0 : sector_reg;
        cnt1    = step1 ? '0 : count_reg;

        si_inc1 = si1 + 1'b1;
        step2   = phase_done(ph1, cnt1, gap_one_reg, gap_two_reg,
                             gap_three_reg, gap_four_a_reg, sector_bytes);
        ph2     = step2 ? adv_phase(ph1, si_inc1, eff_sectors) : ph1;
        si2     = (step2 && ph1 == PH_GAP3) ? si_inc1 : si1;
        cnt2    = step2 ? '0 : cnt1;
    end

    // offset table entry
    assign entry     = count_reg[6:1];
    assign entry_ok  = (SEC_W'(entry) < eff_sectors) && (accum_reg < TABLE_LIMIT);
    assign accum_sum = (ACC_W + 1)'(accum_reg) + (ACC_W + 1)'(raw_len);

    // raw track byte
    always_comb
    begin
        unique case (ph2)
            PH_ISYNC, PH_SSYNC, PH_DSYNC: tbyte = SYNC_BYTE;
            PH_IMARK:                     tbyte = IMARK_BYTE;
            PH_IFC:                       tbyte = IAM_BYTE;
            PH_IDA1, PH_DA1:              tbyte = A1_BYTE;
            PH_IDFE:                      tbyte = IDAM_BYTE;
            PH_DFB:                       tbyte = DAM_BYTE;
            PH_IDCHRN:
            begin
                unique case (cnt2[1:0])
                    2'd0:    tbyte = cyl_reg;
                    2'd1:    tbyte = {7'd0, head_reg};
                    2'd2:    tbyte = {1'b0, si2} + 8'd1;
                    default: tbyte = {6'd0, size_code_reg};
                endcase
            end
            PH_DATA:                      tbyte = data_byte;
            PH_IDCRC, PH_DCRC:            tbyte = (cnt2 == '0) ? crc_reg[15:8] : crc_reg[7:0];
            default:                      tbyte = GAP_BYTE;
        endcase
        crc_base  = ((ph2 == PH_IDA1 || ph2 == PH_DA1) && cnt2 == '0) ? CRC_INIT : crc_reg;
        crc_phase = (ph2 == PH_IDA1) || (ph2 == PH_IDFE) || (ph2 == PH_IDCHRN)
                 || (ph2 == PH_DA1) || (ph2 == PH_DFB) || (ph2 == PH_DATA);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sector_next  = sector_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        cyl_next     = cyl_reg;
        head_next    = head_reg;
        accum_next   = accum_reg;
        overrun_next = overrun_reg;
        res_valid    = 1'b0;
        res_c        = '0;

        if (in_fire)
        begin
            if (!req_type)
            begin
                cyl_next     = cylinder_number;
                head_next    = head_number;
                phase_next   = PH_TABLE;
                count_next   = '0;
                sector_next  = '0;
                pos_next     = '0;
                crc_next     = CRC_INIT;
                accum_next   = ACC_W'(TABLE_BYTES) + ACC_W'(gap_four_a_reg)
                             + ACC_W'(gap_one_reg) + ACC_W'(31);
                overrun_next = layout > LAYOUT_MAX;
            end
            else if (phase_reg == PH_TABLE)
            begin
                res_valid          = 1'b1;
                res_c.layout_error = overrun_reg;
                if (!count_reg[0])
                begin
                    res_c.track_byte = entry_ok ? accum_reg[7:0] : 8'd0;
                end
                else
                begin
                    res_c.track_byte = entry_ok ? {2'b10, accum_reg[13:8]} : 8'd0;
                    accum_next = accum_sum[ACC_W] ? ACC_SAT : accum_sum[ACC_W-1:0];
                end
                if (count_reg == CNT_W'(TABLE_BYTES - 1))
                begin
                    phase_next = PH_GAP4A;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                res_valid          = 1'b1;
                res_c.track_byte   = tbyte;
                res_c.data_taken   = (ph2 == PH_DATA);
                res_c.layout_error = overrun_reg;
                crc_next    = crc_phase ? crc_update(crc_base, tbyte) : crc_base;
                sector_next = si2;
                pos_next    = pos_reg + 1'b1;
                if (((ACC_W + 1)'(pos_reg) + 1'b1) >= POS_LIMIT)
                begin
                    res_c.last_of_track = 1'b1;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    phase_next = ph2;
                    count_next = cnt2 + 1'b1;
                end
            end
        end
    end

    assign res = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            sector_reg  <= '0;
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            cyl_reg     <= '0;
            head_reg    <= 1'b0;
            accum_reg   <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sector_reg  <= sector_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            cyl_reg     <= cyl_next;
            head_reg    <= head_next;
            accum_reg   <= accum_next;
            overrun_reg <= overrun_next;
        end
    end

endmodule

`default_nettype wire

>>> src/mfm_track_formatter.sv
// ----------------------------------------------------------------------------
// mfm_track_formatter
// Builds a raw MFM floppy track image (offset table, then track bytes with
// ID and data CRCs) one byte per request beat.
//
// Usage:
//   config beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set gaps, sector
//   count and size code; cfg_ready is always high.
//   An input beat with req_type 0 latches cylinder and head and starts a
//   track; it returns no result. An input beat with req_type 1 returns the
//   next byte; data_byte is used only when data_taken comes back set.
//   A track is 128 table bytes, then TRACK_BYTES raw bytes, the last of
//   which carries last_of_track. Byte beats while no track is open are
//   dropped with no result.
// Timing:
//   one input beat per cycle while in_ready is high; results are
//   registered. All work sits between the sequencer state registers and
//   the result register, and a two-entry output stage keeps in_ready up
//   while one result waits; in_ready drops only with both entries full.
// Reset: no track open, registers at their defaults, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mfm_track_formatter
#(
    parameter int TRACK_BYTES = 6250
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          req_type,
    input  wire logic [7:0]                    cylinder_number,
    input  wire logic                          head_number,
    input  wire logic [7:0]                    data_byte,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         track_byte,
    output logic                               data_taken,
    output logic                               last_of_track,
    output logic                               layout_error
);
    import mfm_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_item;
    logic    buf_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = !buf_full;
    assign in_fire   = in_valid && in_ready;

    mfm_core #(
        .TRACK_BYTES (TRACK_BYTES)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_fire         (in_fire),
        .req_type        (req_type),
        .cylinder_number (cylinder_number),
        .head_number     (head_number),
        .data_byte       (data_byte),
        .res_valid       (res_valid),
        .res             (res)
    );

    mfm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .full      (buf_full)
    );

    assign track_byte    = out_item.track_byte;
    assign data_taken    = out_item.data_taken;
    assign last_of_track = out_item.last_of_track;
    assign layout_error  = out_item.layout_error;

endmodule

`default_nettype wire

>>> src/mfm_checker.sv
// ----------------------------------------------------------------------------
// mfm_checker
// port-level checks of the track formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mfm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] track_byte,
    input wire logic       data_taken,
    input wire logic       last_of_track,
    input wire logic       layout_error
);

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(track_byte) && $stable(data_taken)
        && $stable(last_of_track) && $stable(layout_error), "stalled result beat changed")

    // intake only stops with a result pending
    `ASSERT_NOW(a_stall_has_result, !in_ready, out_valid, "in_ready low with output empty")

    // full output stage stays full until a result leaves
    `ASSERT_NEXT(a_full_holds, !in_ready && !(out_valid && out_ready), !in_ready,
        "in_ready rose without a result beat")

    // one result leaving frees intake
    `ASSERT_NEXT(a_full_drains, !in_ready && out_valid && out_ready, in_ready && out_valid,
        "output stage did not drain")

endmodule

bind mfm_track_formatter mfm_checker u_mfm_checker (.*);

`default_nettype wire
